FILE: rtl/pas_pkg.sv
// Shared types and codes of the priority aging process scheduler.
package pas_pkg;

    localparam int DEF_MAX_PROCESSES = 16;

    localparam int PID_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int TICK_W  = 24;
    localparam int QUANT_W = 16;
    localparam int LIMIT_W = QUANT_W + PRIO_W + 1;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_EXIT   = 2'd2;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_MAX_PRI = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PRIO_W-1:0] priority_req;
    } t_in;

    typedef struct packed {
        logic              running_valid;
        logic [PID_W-1:0]  running_pid;
        logic [PRIO_W-1:0] running_priority;
        logic              switched;
        logic              rejected;
    } t_out;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } t_slot;

endpackage

FILE: rtl/priority_aging_process_scheduler_core.sv
// Top level of the priority aging process scheduler: sequencer, registers and table.
//
//   channel | direction | handshake                  | beat
//   in      | input     | i_in_valid / o_in_stall    | t_in  (kind, priority_req)
//   out     | output    | o_out_valid / i_out_stall  | t_out (running state, flags)
//   cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One beat at a time; the table port moves one entry at a time, read and then written.
// Create: appended; in priority mode each entry is scanned with a read and a compare,
// then the later entries shifted with a read and a write each, or the scan runs off the end.
// Tick: in priority mode a table read, a limit multiply and a compare.
// Exit: later entries read and shifted down. Rejected create or empty op: output read only.
// Synchronous active-low reset clears counters and config; the table needs none.
// A stalled output beat holds while the next input beat is already accepted.
module priority_aging_process_scheduler_core #(
    parameter int MAX_PROCESSES = pas_pkg::DEF_MAX_PROCESSES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  pas_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output pas_pkg::t_out o_out_data,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import pas_pkg::*;

    localparam int IDX_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_SHIFT_RD = 4'd3;
    localparam logic [3:0] S_SHIFT_WR = 4'd4;
    localparam logic [3:0] S_INSERT   = 4'd5;
    localparam logic [3:0] S_TICK_MUL = 4'd6;
    localparam logic [3:0] S_TICK_CMP = 4'd7;
    localparam logic [3:0] S_EXIT_RD  = 4'd8;
    localparam logic [3:0] S_EXIT_WR  = 4'd9;
    localparam logic [3:0] S_OUT_RD   = 4'd10;
    localparam logic [3:0] S_FINISH   = 4'd11;

    logic [3:0]         r_state, n_state;
    logic [1:0]         r_mode;
    logic [QUANT_W-1:0] r_quantum;
    logic [PRIO_W-1:0]  r_max_pri;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [PID_W-1:0]   r_next_pid, n_next_pid;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_sh, n_sh;
    logic [PRIO_W-1:0]  r_prio, n_prio;
    t_slot              r_word, n_word;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic               r_switched, n_switched;
    logic               r_rejected, n_rejected;
    logic               r_out_valid;
    t_out               r_out;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_slot              mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    t_slot              mem_rdata;

    logic               in_fire;
    logic               out_load;
    logic [CNT_W-1:0]   cur_p1;
    logic [IDX_W-1:0]   cur_adv;
    logic [TICK_W-1:0]  tick_inc;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   sh_p1;
    logic [PRIO_W-1:0]  clamped;

    pas_mem #(
        .DEPTH (MAX_PROCESSES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    assign cur_p1   = CNT_W'(r_cur) + CNT_W'(1);
    assign cur_adv  = (cur_p1 >= r_count) ? '0 : cur_p1[IDX_W-1:0];
    assign tick_inc = (r_tick == '1) ? r_tick : r_tick + TICK_W'(1);
    assign cnt_m1   = r_count - CNT_W'(1);
    assign sh_p1    = CNT_W'(r_sh) + CNT_W'(1);
    assign clamped  = (i_in_data.priority_req > r_max_pri) ? r_max_pri
                                                           : i_in_data.priority_req;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cur      = r_cur;
        n_tick     = r_tick;
        n_next_pid = r_next_pid;
        n_pos      = r_pos;
        n_sh       = r_sh;
        n_prio     = r_prio;
        n_word     = r_word;
        n_limit    = r_limit;
        n_switched = r_switched;
        n_rejected = r_rejected;
        mem_we     = 1'b0;
        mem_waddr  = r_pos;
        mem_wdata  = mem_rdata;
        mem_raddr  = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_switched = 1'b0;
                    n_rejected = 1'b0;
                    n_state    = S_OUT_RD;
                    if (i_in_data.kind == KIND_CREATE) begin
                        n_prio = clamped;
                        if (r_count == CNT_W'(MAX_PROCESSES)) begin
                            n_rejected = 1'b1;
                        end else if (r_mode == MODE_PRIO) begin
                            n_pos   = '0;
                            n_state = S_SCAN_RD;
                        end else begin
                            n_pos   = r_count[IDX_W-1:0];
                            n_state = S_INSERT;
                        end
                    end else if (i_in_data.kind == KIND_TICK && r_count != '0) begin
                        if (r_mode == MODE_RR) begin
                            n_tick = tick_inc;
                            if (tick_inc >= TICK_W'(r_quantum) && r_count > CNT_W'(1)) begin
                                n_cur      = cur_adv;
                                n_tick     = '0;
                                n_switched = 1'b1;
                            end
                        end else if (r_mode == MODE_PRIO) begin
                            n_tick    = tick_inc;
                            mem_raddr = r_cur;
                            n_state   = S_TICK_MUL;
                        end
                    end else if (i_in_data.kind == KIND_EXIT && r_count != '0) begin
                        n_sh    = r_cur;
                        n_state = S_EXIT_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (CNT_W'(r_pos) == r_count) begin
                    n_state = S_INSERT;
                end else begin
                    mem_raddr = r_pos;
                    n_state   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (r_prio <= mem_rdata.prio) begin
                    n_pos   = r_pos + IDX_W'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_sh    = r_count[IDX_W-1:0];
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                mem_raddr = r_sh - IDX_W'(1);
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sh;
                mem_wdata = mem_rdata;
                n_sh      = r_sh - IDX_W'(1);
                n_state   = (r_sh - IDX_W'(1) == r_pos) ? S_INSERT : S_SHIFT_RD;
            end
            S_INSERT: begin
                mem_we         = 1'b1;
                mem_waddr      = r_pos;
                mem_wdata.pid  = r_next_pid;
                mem_wdata.prio = r_prio;
                n_next_pid     = r_next_pid + PID_W'(1);
                n_count        = r_count + CNT_W'(1);
                n_switched     = (r_count == '0);
                if (r_count != '0 && r_pos <= r_cur) begin
                    n_cur = r_cur + IDX_W'(1);
                end
                n_state = S_OUT_RD;
            end
            S_TICK_MUL: begin
                n_word  = mem_rdata;
                n_limit = LIMIT_W'(r_quantum) *
                          LIMIT_W'(9'(mem_rdata.prio) + 9'd1);
                n_state = S_TICK_CMP;
            end
            S_TICK_CMP: begin
                if (LIMIT_W'(r_tick) >= r_limit) begin
                    if (r_word.prio != '0) begin
                        mem_we         = 1'b1;
                        mem_waddr      = r_cur;
                        mem_wdata.pid  = r_word.pid;
                        mem_wdata.prio = r_word.prio - PRIO_W'(1);
                    end
                    n_tick = '0;
                    if (r_count > CNT_W'(1)) begin
                        n_cur      = cur_adv;
                        n_switched = 1'b1;
                    end
                end
                n_state = S_OUT_RD;
            end
            S_EXIT_RD: begin
                if (sh_p1 >= r_count) begin
                    n_count    = cnt_m1;
                    n_switched = (cnt_m1 != '0);
                    if (CNT_W'(r_cur) >= cnt_m1) begin
                        n_cur = '0;
                    end
                    n_state = S_OUT_RD;
                end else begin
                    mem_raddr = sh_p1[IDX_W-1:0];
                    n_state   = S_EXIT_WR;
                end
            end
            S_EXIT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sh;
                mem_wdata = mem_rdata;
                n_sh      = r_sh + IDX_W'(1);
                n_state   = S_EXIT_RD;
            end
            S_OUT_RD: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_FCFS;
            r_quantum   <= QUANT_W'(10);
            r_max_pri   <= PRIO_W'(99);
            r_count     <= '0;
            r_cur       <= '0;
            r_tick      <= '0;
            r_next_pid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cur      <= n_cur;
            r_tick     <= n_tick;
            r_next_pid <= n_next_pid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:    r_mode    <= i_cfg_data[1:0];
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    CFG_MAX_PRI: r_max_pri <= i_cfg_data[PRIO_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_sh       <= n_sh;
        r_prio     <= n_prio;
        r_word     <= n_word;
        r_limit    <= n_limit;
        r_switched <= n_switched;
        r_rejected <= n_rejected;
        if (out_load) begin
            r_out.running_valid    <= (r_count != '0);
            r_out.running_pid      <= (r_count != '0) ? mem_rdata.pid : '0;
            r_out.running_priority <= (r_count != '0) ? mem_rdata.prio : '0;
            r_out.switched         <= r_switched;
            r_out.rejected         <= r_rejected;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/pas_mem.sv
// Process table memory: one write port, one registered read port.
module pas_mem #(
    parameter int DEPTH = pas_pkg::DEF_MAX_PROCESSES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  pas_pkg::t_slot           i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output pas_pkg::t_slot           o_rdata
);
    import pas_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pas_checker.sv
// Port-level checks on the scheduler top level, bound to every instance.
module pas_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input pas_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the beat was processed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.running_valid |->
            o_out_data.running_pid == '0 && o_out_data.running_priority == '0
            && !o_out_data.switched)
        else $error("empty table reports a running process");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rejected |->
            o_out_data.running_valid && !o_out_data.switched)
        else $error("rejected create with empty table or switch");

endmodule

bind priority_aging_process_scheduler_core pas_checker u_pas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: verif/sched_tb_pkg.sv
// Scoreboard that predicts the running process after each scheduler request.
package sched_tb_pkg;
    import pas_pkg::*;

    localparam int          TABLE_SLOTS = DEF_MAX_PROCESSES;
    localparam int unsigned TICK_MAX    = (1 << TICK_W) - 1;
    localparam logic [1:0]  KIND_NONE   = 2'd3;
    localparam logic [1:0]  MODE_SPARE  = 2'd3;
    localparam logic [1:0]  CFG_NONE    = 2'd3;

    class run_scoreboard;
        logic [1:0]        mode;
        logic [QUANT_W-1:0] quantum;
        logic [PRIO_W-1:0] max_pri;
        logic [PID_W-1:0]  pid_tab [TABLE_SLOTS];
        logic [PRIO_W-1:0] pri_tab [TABLE_SLOTS];
        int                count;
        int                cur;
        int unsigned       ticks;
        logic [PID_W-1:0]  next_pid;
        t_out              expected_running [$];
        int                errors;

        function new();
            mode     = MODE_FCFS;
            quantum  = 16'd10;
            max_pri  = 8'd99;
            count    = 0;
            cur      = 0;
            ticks    = 0;
            next_pid = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_MODE: begin
                    mode = data[1:0];
                end
                CFG_QUANTUM: begin
                    quantum = data;
                end
                CFG_MAX_PRI: begin
                    max_pri = data[PRIO_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void next_slot();
            cur++;
            if (cur >= count)
                cur = 0;
        endfunction

        function void note_request(t_in req);
            t_out              res;
            logic [PRIO_W-1:0] prio;
            int                pos;
            int                i;
            int unsigned       lim;
            res = '0;
            case (req.kind)
                KIND_CREATE: begin
                    if (count >= TABLE_SLOTS) begin
                        res.rejected = 1'b1;
                    end else begin
                        prio = (req.priority_req > max_pri) ? max_pri : req.priority_req;
                        pos = count;
                        if (mode == MODE_PRIO) begin
                            pos = 0;
                            while (pos < count && prio <= pri_tab[pos])
                                pos++;
                        end
                        for (i = count; i > pos; i--) begin
                            pid_tab[i] = pid_tab[i-1];
                            pri_tab[i] = pri_tab[i-1];
                        end
                        pid_tab[pos] = next_pid;
                        pri_tab[pos] = prio;
                        next_pid++;
                        if (count > 0 && pos <= cur)
                            cur++;
                        res.switched = (count == 0);
                        count++;
                    end
                end
                KIND_TICK: begin
                    if (count > 0 && mode == MODE_RR) begin
                        if (ticks < TICK_MAX)
                            ticks++;
                        if (ticks >= int'(quantum) && count > 1) begin
                            next_slot();
                            ticks = 0;
                            res.switched = 1'b1;
                        end
                    end else if (count > 0 && mode == MODE_PRIO) begin
                        if (ticks < TICK_MAX)
                            ticks++;
                        lim = int'(quantum) * (1 + int'(pri_tab[cur]));
                        if (ticks >= lim) begin
                            if (pri_tab[cur] != 0)
                                pri_tab[cur]--;
                            ticks = 0;
                            if (count > 1) begin
                                next_slot();
                                res.switched = 1'b1;
                            end
                        end
                    end
                end
                KIND_EXIT: begin
                    if (count > 0) begin
                        for (i = cur; i + 1 < count; i++) begin
                            pid_tab[i] = pid_tab[i+1];
                            pri_tab[i] = pri_tab[i+1];
                        end
                        count--;
                        if (cur >= count)
                            cur = 0;
                        res.switched = (count > 0);
                    end
                end
                default: begin
                end
            endcase
            if (count > 0) begin
                res.running_valid    = 1'b1;
                res.running_pid      = pid_tab[cur];
                res.running_priority = pri_tab[cur];
            end
            expected_running.insert(expected_running.size(), res);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_running.size() == 0) begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            want = expected_running.pop_front();
            compare("running_valid", want.running_valid, got.running_valid);
            compare("running_pid", want.running_pid, got.running_pid);
            compare("running_priority", want.running_priority, got.running_priority);
            compare("switched", want.switched, got.switched);
            compare("rejected", want.rejected, got.rejected);
        endfunction
    endclass

endpackage

FILE: verif/tb_top.sv
// Top-level testbench of the priority aging process scheduler core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pas_pkg::*;
    import sched_tb_pkg::*;

    localparam int SLOTS        = TABLE_SLOTS;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4 * SLOTS + 8;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 52;

    localparam logic [1:0] PHASE_MODE [PHASES] = '{MODE_PRIO, MODE_RR, MODE_PRIO, MODE_FCFS,
        MODE_RR, MODE_SPARE, MODE_PRIO, MODE_RR, MODE_PRIO, MODE_FCFS};
    localparam logic [15:0] PHASE_QUANTUM [PHASES] = '{16'd1, 16'd65535, 16'd2, 16'd3,
        16'd1, 16'd0, 16'd0, 16'd2, 16'd65535, 16'd5};
    localparam logic [7:0] PHASE_MAX_PRI [PHASES] = '{8'd255, 8'd0, 8'd3, 8'd255,
        8'd7, 8'd1, 8'd255, 8'd99, 8'd5, 8'd128};

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [15:0] i_cfg_data = '0;

    run_scoreboard sb = new();
    t_in           req_q [$];
    int            idle_pct   = 35;
    int            stall_pct  = 35;
    int            hold_token = 0;
    int            hold_seen  = 0;
    int            hold_left  = 0;

    priority_aging_process_scheduler_core #(
        .MAX_PROCESSES(SLOTS)
    ) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic void add_request(logic [1:0] kind, logic [7:0] prio);
        t_in beat;
        beat.kind         = kind;
        beat.priority_req = prio;
        req_q.insert(req_q.size(), beat);
    endfunction

    task automatic play_requests();
        t_in beat;
        while (req_q.size() != 0) begin
            beat = req_q.pop_front();
            i_in_valid <= 1'b1;
            i_in_data  <= beat;
            do @(posedge i_clk); while (o_in_stall);
            sb.note_request(beat);
            if (req_q.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
            end
        end
    endtask

    task automatic wait_idle();
        while (sb.expected_running.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        int made;
        int pick;
        int len;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            if (sb.count == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) add_request(KIND_CREATE, 8'($urandom));
            end else if (pick < 20) begin
                // fill the table and run into it
                len = SLOTS - sb.count + $urandom_range(1, 2);
                repeat (len) add_request(KIND_CREATE, 8'($urandom));
            end else if (pick < 60) begin
                len = $urandom_range(1, 24);
                repeat (len) add_request(KIND_TICK, 8'($urandom));
            end else if (pick < 75) begin
                len = $urandom_range(1, 4);
                repeat (len) add_request(KIND_EXIT, 8'($urandom));
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) add_request(2'($urandom), 8'($urandom));
            end
            made += len;
            play_requests();
        end
    endtask

    initial begin
        int ph;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_request(KIND_TICK, 8'h00);
        add_request(KIND_EXIT, 8'h00);
        add_request(KIND_NONE, 8'hFF);
        add_request(KIND_CREATE, 8'hFF);
        add_request(KIND_CREATE, 8'h00);
        add_request(KIND_TICK, 8'h55);
        add_request(KIND_NONE, 8'hAA);
        add_request(KIND_EXIT, 8'h00);
        add_request(KIND_EXIT, 8'h00);
        add_request(KIND_EXIT, 8'h00);
        play_requests();
        wait_idle();

        write_reg(CFG_MODE, 16'(MODE_PRIO));
        write_reg(CFG_QUANTUM, 16'd0);
        write_reg(CFG_MAX_PRI, 16'hFFFF);
        write_reg(CFG_NONE, 16'hFFFF);
        add_request(KIND_CREATE, 8'd5);
        add_request(KIND_CREATE, 8'd255);
        add_request(KIND_CREATE, 8'd5);
        add_request(KIND_CREATE, 8'd0);
        add_request(KIND_TICK, 8'd0);
        add_request(KIND_TICK, 8'd0);
        add_request(KIND_TICK, 8'd0);
        add_request(KIND_EXIT, 8'd0);
        play_requests();
        wait_idle();

        write_reg(CFG_MODE, 16'(MODE_RR));
        write_reg(CFG_QUANTUM, 16'd1);
        add_request(KIND_TICK, 8'd0);
        add_request(KIND_TICK, 8'd0);
        add_request(KIND_EXIT, 8'd0);
        play_requests();
        wait_idle();

        write_reg(CFG_MODE, 16'(MODE_SPARE));
        add_request(KIND_TICK, 8'd0);
        add_request(KIND_CREATE, 8'd7);
        play_requests();
        wait_idle();

        for (ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_MODE, {14'($urandom), PHASE_MODE[ph]});
            write_reg(CFG_QUANTUM, PHASE_QUANTUM[ph]);
            write_reg(CFG_MAX_PRI, {8'($urandom), PHASE_MAX_PRI[ph]});
            if (ph == 2)
                hold_token <= hold_token + 1;
            if (ph == 3) begin
                idle_pct = 0;
                stall_pct <= 0;
            end
            random_phase(PHASE_ITEMS);
            idle_pct = 35;
            stall_pct <= 35;
            wait_idle();
        end

        write_reg(CFG_MODE, 16'(MODE_FCFS));
        write_reg(CFG_MAX_PRI, 16'd255);
        while (sb.count != 0) begin
            add_request(KIND_EXIT, 8'($urandom));
            play_requests();
        end
        random_phase(20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_running.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/pas_pkg.sv
rtl/pas_mem.sv
rtl/priority_aging_process_scheduler_core.sv
rtl/pas_checker.sv
verif/sched_tb_pkg.sv
verif/tb_top.sv
